// ===== sv/lfkc_pkg.sv =====
package lfkc_pkg;

   // field and word widths, stage count, index width and queue depth
   localparam int DATA_W      = 8;
   localparam int WORD_W      = 16;
   localparam int NUM_STAGES  = 16;
   localparam int CSR_INDEX_W = 1;
   localparam int QUEUE_DEPTH = 2;

   // first FSM register value after a key load is this minus the top stage
   localparam logic [WORD_W-1:0] R1_LOAD_BASE = 16'hFFFF;

   // configuration register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LFSR_KEY = 1'b0,
      CSR_FSM_KEY  = 1'b1
   } csr_index_type;

   // one configuration write
   typedef struct packed {
      logic                 we;
      csr_index_type        index;
      logic [WORD_W-1:0]    wdata;
   } csr_write_type;

   // one queued input item
   typedef struct packed {
      logic                 start;
      logic [DATA_W-1:0]    data;
   } item_type;

   // byte substitution table
   localparam logic [7:0] SBOX_TABLE [256] = '{
      8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
      8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
      8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
      8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
      8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
      8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
      8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
      8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
      8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
      8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
      8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
      8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
      8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
      8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
      8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
      8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
      8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
      8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
      8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
      8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
      8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
      8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
      8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
      8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
      8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
      8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
      8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
      8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
      8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
      8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
      8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
      8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
   };

endpackage

// ===== sv/lfkc_front.sv =====
module lfkc_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [lfkc_pkg::DATA_W-1:0]       req_tdata,
   input  logic [0:0]                        req_tuser,
   output logic                              q_valid,
   output lfkc_pkg::item_type                q_item,
   input  logic                              q_pop
);
   import lfkc_pkg::*;

   item_type   slot_ff [QUEUE_DEPTH];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       push;
   item_type   new_item;

   // accept while a slot is free
   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready;

   // tag the item with its start flag
   always_comb begin
      new_item.start = req_tuser[0];
      new_item.data  = req_tdata;
   end

   // queue head toward the back part
   assign q_valid = (count_ff != 2'd0);
   assign q_item  = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push  ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      case ({push, q_pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

// ===== sv/lfkc_back.sv =====
module lfkc_back (
   input  logic                              clock,
   input  logic                              reset,
   input  lfkc_pkg::csr_write_type           csr,
   input  logic                              q_valid,
   input  lfkc_pkg::item_type                q_item,
   output logic                              q_pop,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [lfkc_pkg::DATA_W-1:0]       rsp_tdata
);
   import lfkc_pkg::*;

   logic [WORD_W-1:0]   lfsr_key_ff;
   logic [WORD_W-1:0]   fsm_key_ff;
   logic [WORD_W-1:0]   stage_ff [NUM_STAGES];
   logic [WORD_W-1:0]   stage_in [NUM_STAGES];
   logic [WORD_W-1:0]   stage_eff [NUM_STAGES];
   logic [WORD_W-1:0]   r1_ff;
   logic [WORD_W-1:0]   r1_in;
   logic [WORD_W-1:0]   r1_eff;
   logic [WORD_W-1:0]   r2_ff;
   logic [WORD_W-1:0]   r2_in;
   logic [WORD_W-1:0]   r2_eff;
   logic [WORD_W-1:0]   held_ff;
   logic [WORD_W-1:0]   held_in;
   logic                odd_ff;
   logic                odd_in;
   logic                odd_eff;
   logic [WORD_W-1:0]   sum;
   logic [WORD_W-1:0]   fout;
   logic [WORD_W-1:0]   zword;
   logic [WORD_W:0]     swide;
   logic [WORD_W-1:0]   rot;
   logic [WORD_W-1:0]   feedback;
   logic                rsp_tvalid_ff;
   logic                rsp_tvalid_in;
   logic [DATA_W-1:0]   rsp_tdata_ff;
   logic [DATA_W-1:0]   rsp_tdata_in;

   // key registers
   always_ff @(posedge clock) begin
      if (reset) begin
         lfsr_key_ff <= '0;
         fsm_key_ff  <= '0;
      end else if (csr.we) begin
         case (csr.index)
            CSR_LFSR_KEY: lfsr_key_ff <= csr.wdata;
            CSR_FSM_KEY:  fsm_key_ff  <= csr.wdata;
            default: ;
         endcase
      end
   end

   // take the next item when the output register is free or draining
   assign q_pop = q_valid && (!rsp_tvalid_ff || rsp_tready);

   // state seen by this item: key load on start, else current state
   always_comb begin
      for (int i = 0; i < NUM_STAGES; i++) begin
         stage_eff[i] = q_item.start ? WORD_W'(lfsr_key_ff >> i) : stage_ff[i];
      end
      r1_eff  = q_item.start ? (R1_LOAD_BASE - stage_eff[NUM_STAGES-1]) : r1_ff;
      r2_eff  = q_item.start ? fsm_key_ff : r2_ff;
      odd_eff = q_item.start ? 1'b0 : odd_ff;
   end

   // keystream word and fsm update
   always_comb begin
      sum      = stage_eff[NUM_STAGES-1] + r1_eff;
      fout     = sum ^ r2_eff;
      zword    = fout ^ stage_eff[0];
      swide    = {1'b0, fout} + {1'b0, r2_eff};
      rot      = {swide[8:0], 7'b0} | {8'b0, swide[WORD_W:9]};
      feedback = stage_eff[0] ^ stage_eff[3] ^ stage_eff[9];
   end

   // next state
   always_comb begin
      for (int i = 0; i < NUM_STAGES; i++) begin
         stage_in[i] = stage_ff[i];
      end
      r1_in         = r1_ff;
      r2_in         = r2_ff;
      held_in       = held_ff;
      odd_in        = odd_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      if (q_pop) begin
         rsp_tvalid_in = 1'b1;
         odd_in        = ~odd_eff;
         for (int i = 0; i < NUM_STAGES; i++) begin
            stage_in[i] = stage_eff[i];
         end
         r1_in = r1_eff;
         r2_in = r2_eff;
         if (!odd_eff) begin
            // even position: step the generator and hold the new word
            for (int i = 0; i < NUM_STAGES - 1; i++) begin
               stage_in[i] = stage_eff[i+1];
            end
            stage_in[NUM_STAGES-1] = feedback;
            r1_in        = r1_eff ^ rot;
            r2_in        = {SBOX_TABLE[r1_eff[15:8]], SBOX_TABLE[r1_eff[7:0]]};
            held_in      = zword;
            rsp_tdata_in = q_item.data ^ zword[15:8];
         end else begin
            rsp_tdata_in = q_item.data ^ held_ff[7:0];
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_STAGES; i++) begin
            stage_ff[i] <= '0;
         end
         r1_ff         <= '0;
         r2_ff         <= '0;
         held_ff       <= '0;
         odd_ff        <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         for (int i = 0; i < NUM_STAGES; i++) begin
            stage_ff[i] <= stage_in[i];
         end
         r1_ff         <= r1_in;
         r2_ff         <= r2_in;
         held_ff       <= held_in;
         odd_ff        <= odd_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

// ===== sv/lfsr_fsm_keystream_cipher_unit.sv =====
// Keystream byte cipher, shift register of 16-bit words and two-register FSM.
// req channel: one byte per transfer; req_tuser[0] marks the first byte
//   of a message and reloads the generator from the two key registers.
// rsp channel: one byte per request, the input byte XOR a keystream byte,
//   in request order. Even positions take the high byte of a fresh word,
//   odd positions the low byte of the held word.
// csr port: csr_we with csr_index 0 writes the shift register key, 1 the
//   FSM key. Keys take effect at the next start of message; write them
//   only while no transfer is in flight.
// A req transfer passes through a queue slot, then the output register, before
//   rsp_tvalid rises. Throughput: one byte per cycle while rsp_tready holds no
//   result back, set by the combinational generator step (add, rotate, two
//   table lookups) in the back stage.
// A two-entry queue sits between the input and the generator, and the
//   result sits in an output register, so a stalled rsp_tready fills the
//   queue before req_tready drops.
// Reset clears the generator state, keys, queue and output valid.
module lfsr_fsm_keystream_cipher_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [lfkc_pkg::DATA_W-1:0]         req_tdata,   // data_byte
   input  logic [0:0]                          req_tuser,   // start_of_message
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [lfkc_pkg::DATA_W-1:0]         rsp_tdata,   // result_byte
   input  logic                                csr_we,
   input  logic [lfkc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [lfkc_pkg::WORD_W-1:0]         csr_wdata
);
   import lfkc_pkg::*;

   csr_write_type csr;
   logic          q_valid;
   item_type      q_item;
   logic          q_pop;

   // bundle the configuration write
   always_comb begin
      csr.we    = csr_we;
      csr.index = csr_index_type'(csr_index);
      csr.wdata = csr_wdata;
   end

   lfkc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   lfkc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr        (csr),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
